### rtl/swbd_pkg.sv
// Shared types and constants for the significant-word bit decoder.
// No dependencies; every other file of the block imports this package.
package swbd_pkg;

  // Field and register widths
  localparam int unsigned WORD_W   = 32;  // decoded word, two's complement
  localparam int unsigned N_W      = 5;   // range exponent register
  localparam int unsigned ACC_W    = 31;  // gathered bits of the unsigned code
  localparam int unsigned RUN_W    = 4;   // prefix run counter
  localparam int unsigned TOP_W    = 4;   // value carried by the prefix
  localparam int unsigned APB_AW   = 3;   // byte address of two 32-bit registers
  localparam int unsigned APB_DW   = 32;

  // Range of n in each coding mode
  localparam logic [N_W-1:0] MIN_N     = N_W'(3);
  localparam logic [N_W-1:0] MAX_N     = N_W'(24);
  localparam logic [N_W-1:0] PCM_MIN_N = N_W'(1);
  localparam logic [N_W-1:0] PCM_MAX_N = N_W'(30);

  // Prefix code constants
  localparam logic [RUN_W-1:0] PREFIX_MAX_LEN = RUN_W'(8);
  localparam logic [TOP_W-1:0] TOP_OFFSET     = TOP_W'(7);
  localparam logic [TOP_W-1:0] TOP_MIN        = TOP_W'(0);
  localparam logic [TOP_W-1:0] TOP_MAX        = TOP_W'(15);
  localparam logic [N_W-1:0]   TOP_BITS       = N_W'(3);

  // Register indexes
  localparam logic REG_CODE_MODE = 1'b0;
  localparam logic REG_WORD_BITS = 1'b1;

  // Coding modes
  localparam logic MODE_HUFFMAN = 1'b0;
  localparam logic MODE_PCM     = 1'b1;

  // Reset value of word_bits
  localparam logic [N_W-1:0] WORD_BITS_RST = N_W'(16);

  // Decoder phase
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_PREFIX = 2'd1,
    PH_RAW    = 2'd2
  } phase_t;

endpackage

### rtl/swbd_bit_if.sv
// Input channel of the decoder: one coded bit per handshake.
// Depends on swbd_pkg.
interface swbd_bit_if
  import swbd_pkg::*;
();
  logic valid;
  logic ready;
  logic bit_in;

  modport source (output valid, output bit_in, input ready);
  modport sink   (input valid, input bit_in, output ready);
endinterface

### rtl/swbd_word_if.sv
// Result channel of the decoder: one decoded signed word per handshake.
// Depends on swbd_pkg.
interface swbd_word_if
  import swbd_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] word_value;

  modport source (output valid, output word_value, input ready);
  modport sink   (input valid, input word_value, output ready);
endinterface

### rtl/significant_word_bit_decoder.sv
// Significant-word bit decoder: top level with the decode logic and APB registers.
// Depends on swbd_pkg, swbd_bit_if and swbd_word_if.
//
// The decoder takes one coded bit per clock cycle, most significant first, and
// produces a signed word each time a word completes. Each bit is decoded against
// the phase registers in a single pass and a finished word is written to an
// output register, so the result appears in the cycle after the bit that ends the
// word. The input stays ready while the output register is empty or being
// drained, which gives a sustained rate of one bit per cycle; it stalls only
// while a finished word waits at the output. In Huffman mode a word takes the
// prefix (two to eight bits) plus n-3 raw bits; in PCM mode it takes n+1 bits.
// Any register write drops a word in progress.
module significant_word_bit_decoder
  import swbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  swbd_bit_if.sink          in_s,
  swbd_word_if.source       out_m,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // Configuration registers
  logic           code_mode_r;
  logic [N_W-1:0] word_bits_r;

  // Decoder state
  phase_t           phase_r, phase_nxt;
  logic             first_bit_r, first_bit_nxt;
  logic [RUN_W-1:0] run_count_r, run_count_nxt;
  logic [ACC_W-1:0] raw_accum_r, raw_accum_nxt;
  logic [N_W-1:0]   raw_left_r, raw_left_nxt;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  logic signed [WORD_W-1:0] out_word_r;

  logic             cfg_wr;
  logic             accept;
  logic             b;
  logic [N_W-1:0]   eff_n;
  logic [N_W-1:0]   raw_count;
  logic [RUN_W-1:0] run_inc;
  logic             prefix_done;
  logic [TOP_W-1:0] top;
  logic [ACC_W-1:0] acc_shift;
  logic [N_W-1:0]   left_dec;
  logic             emit;
  logic [ACC_W-1:0] emit_acc;
  logic [WORD_W-1:0] word_calc;

  // APB write strobe and read mux
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_CODE_MODE: prdata = {{(APB_DW-1){1'b0}}, code_mode_r};
      REG_WORD_BITS: prdata = {{(APB_DW-N_W){1'b0}}, word_bits_r};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_mode_r <= MODE_HUFFMAN;
      word_bits_r <= WORD_BITS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_CODE_MODE: code_mode_r <= pwdata[0];
        REG_WORD_BITS: word_bits_r <= pwdata[N_W-1:0];
        default:       ;
      endcase
    end
  end

  // Handshake: take a bit while the output register is free or draining
  assign in_s.ready = !out_valid_r || out_m.ready;
  assign accept     = in_s.valid && in_s.ready;
  assign b          = in_s.bit_in;

  // Clamp n to the range of the active mode
  always_comb begin
    eff_n = word_bits_r;
    if (code_mode_r == MODE_PCM) begin
      if (word_bits_r < PCM_MIN_N) eff_n = PCM_MIN_N;
      if (word_bits_r > PCM_MAX_N) eff_n = PCM_MAX_N;
    end else begin
      if (word_bits_r < MIN_N) eff_n = MIN_N;
      if (word_bits_r > MAX_N) eff_n = MAX_N;
    end
  end

  // Shared decode terms
  assign raw_count = eff_n - TOP_BITS;
  assign run_inc   = run_count_r + RUN_W'(1);
  assign acc_shift = {raw_accum_r[ACC_W-2:0], b};
  assign left_dec  = raw_left_r - N_W'(1);

  // Prefix end: a differing bit, or the run reaching its maximum length
  always_comb begin
    prefix_done = 1'b0;
    top         = TOP_MIN;
    if (b != first_bit_r) begin
      prefix_done = 1'b1;
      top = first_bit_r ? (run_count_r + TOP_OFFSET)
                        : (TOP_OFFSET + TOP_W'(1) - run_count_r);
    end else if (run_inc >= PREFIX_MAX_LEN) begin
      prefix_done = 1'b1;
      top = first_bit_r ? TOP_MAX : TOP_MIN;
    end
  end

  // Output decode: word completes on this bit
  always_comb begin
    emit     = 1'b0;
    emit_acc = acc_shift;
    unique case (phase_r)
      PH_PREFIX: begin
        emit     = prefix_done && (raw_count == '0);
        emit_acc = {{(ACC_W-TOP_W){1'b0}}, top};
      end
      PH_RAW: begin
        emit = (left_dec == '0);
      end
      default: ;
    endcase
  end

  // Remove the offset 2^n - 1
  assign word_calc = {1'b0, emit_acc} - ((WORD_W'(1) << eff_n) - WORD_W'(1));

  // Next state
  always_comb begin
    phase_nxt     = phase_r;
    first_bit_nxt = first_bit_r;
    run_count_nxt = run_count_r;
    raw_accum_nxt = raw_accum_r;
    raw_left_nxt  = raw_left_r;
    if (cfg_wr || (accept && emit)) begin
      // drop or close the word
      phase_nxt     = PH_IDLE;
      first_bit_nxt = 1'b0;
      run_count_nxt = '0;
      raw_accum_nxt = '0;
      raw_left_nxt  = '0;
    end else if (accept) begin
      unique case (phase_r)
        PH_PREFIX: begin
          if (prefix_done) begin
            run_count_nxt = '0;
            raw_accum_nxt = {{(ACC_W-TOP_W){1'b0}}, top};
            raw_left_nxt  = raw_count;
            phase_nxt     = PH_RAW;
          end else begin
            run_count_nxt = run_inc;
          end
        end
        PH_RAW: begin
          raw_accum_nxt = acc_shift;
          raw_left_nxt  = left_dec;
        end
        default: begin
          if (code_mode_r == MODE_PCM) begin
            raw_accum_nxt = {{(ACC_W-1){1'b0}}, b};
            raw_left_nxt  = eff_n;
            phase_nxt     = PH_RAW;
          end else begin
            first_bit_nxt = b;
            run_count_nxt = RUN_W'(1);
            phase_nxt     = PH_PREFIX;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      first_bit_r <= 1'b0;
      run_count_r <= '0;
      raw_accum_r <= '0;
      raw_left_r  <= '0;
    end else begin
      phase_r     <= phase_nxt;
      first_bit_r <= first_bit_nxt;
      run_count_r <= run_count_nxt;
      raw_accum_r <= raw_accum_nxt;
      raw_left_r  <= raw_left_nxt;
    end
  end

  // Output register: load a finished word, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_m.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_word_r <= $signed(word_calc);
    end
  end

  assign out_m.valid      = out_valid_r;
  assign out_m.word_value = out_word_r;

endmodule
